>>> hdl/pns_pkg.sv
// ----------------------------------------------------------------------------
// pns_pkg: shared types and widths
// Field widths, stored record layouts and the pick result of the select unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pns_pkg;

    localparam int BURST_W = 16;
    localparam int ARR_W   = 16;
    localparam int PRIO_W  = 8;
    localparam int TICK_W  = 23;
    localparam int DIFF_W  = 22;
    localparam int SUM_W   = 28;
    localparam int PIDX_W  = 6;

    // one loaded process
    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [ARR_W-1:0]   arrival;
        logic [PRIO_W-1:0]  prio;
    } job_rec_t;

    // start and finish ticks of a scheduled process
    typedef struct packed {
        logic [TICK_W-1:0] start;
        logic [TICK_W-1:0] finish;
    } span_t;

    // outcome of one selection pass
    typedef struct packed {
        logic [PIDX_W-1:0]  idx;
        logic [TICK_W-1:0]  start;
        logic [BURST_W-1:0] burst;
    } pick_t;

endpackage

`default_nettype wire

>>> hdl/pns_job_if.sv
// ----------------------------------------------------------------------------
// pns_job_if: process input channel
// Valid/ready channel carrying one process description per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pns_job_if;
    logic        valid;
    logic        ready;
    logic [15:0] burst_time;
    logic [15:0] arrival_time;
    logic [7:0]  priority_level;
    logic        last_process;

    modport source (
        output valid, burst_time, arrival_time, priority_level, last_process,
        input  ready
    );
    modport sink (
        input  valid, burst_time, arrival_time, priority_level, last_process,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/pns_result_if.sv
// ----------------------------------------------------------------------------
// pns_result_if: per-process result channel
// Valid/ready channel carrying one process's timing figures per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pns_result_if;
    logic        valid;
    logic        ready;
    logic [5:0]  process_index;
    logic [22:0] completion_time;
    logic [21:0] turnaround_time;
    logic [21:0] waiting_time;
    logic [21:0] response_time;
    logic [27:0] total_turnaround;
    logic [27:0] total_waiting;
    logic [27:0] total_response;
    logic        last_result;

    modport source (
        output valid, process_index, completion_time, turnaround_time,
               waiting_time, response_time, total_turnaround, total_waiting,
               total_response, last_result,
        input  ready
    );
    modport sink (
        input  valid, process_index, completion_time, turnaround_time,
               waiting_time, response_time, total_turnaround, total_waiting,
               total_response, last_result,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/pns_ram.sv
// ----------------------------------------------------------------------------
// pns_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/pns_select.sv
// ----------------------------------------------------------------------------
// pns_select: shared selection unit
// Sees one stored process per sampled cycle and keeps the best ready candidate and
// the earliest pending one; their merge is the next process to start.
// ----------------------------------------------------------------------------
`default_nettype none

module pns_select
    import pns_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               clear,
    input  wire logic               sample,
    input  wire logic [PIDX_W-1:0]  idx,
    input  wire job_rec_t           job,
    input  wire logic               done,
    input  wire logic [TICK_W-1:0]  tick,
    output pick_t                   pick
);

    // best among arrived: priority, then arrival, then index
    logic               rdy_found_reg, rdy_found_next;
    logic [PRIO_W-1:0]  rdy_prio_reg;
    logic [ARR_W-1:0]   rdy_arr_reg;
    logic [PIDX_W-1:0]  rdy_idx_reg;
    logic [BURST_W-1:0] rdy_burst_reg;
    // earliest pending: arrival, then priority, then index
    logic               erl_found_reg, erl_found_next;
    logic [PRIO_W-1:0]  erl_prio_reg;
    logic [ARR_W-1:0]   erl_arr_reg;
    logic [PIDX_W-1:0]  erl_idx_reg;
    logic [BURST_W-1:0] erl_burst_reg;

    logic rdy_take;
    logic erl_take;
    logic arrived;

    assign arrived  = {{(TICK_W-ARR_W){1'b0}}, job.arrival} <= tick;

    assign rdy_take = sample && !done && arrived &&
                      (!rdy_found_reg || job.prio < rdy_prio_reg ||
                       (job.prio == rdy_prio_reg && job.arrival < rdy_arr_reg));

    assign erl_take = sample && !done &&
                      (!erl_found_reg || job.arrival < erl_arr_reg ||
                       (job.arrival == erl_arr_reg && job.prio < erl_prio_reg));

    assign rdy_found_next = clear ? 1'b0 : (rdy_found_reg || rdy_take);
    assign erl_found_next = clear ? 1'b0 : (erl_found_reg || erl_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdy_found_reg <= 1'b0;
            erl_found_reg <= 1'b0;
        end
        else
        begin
            rdy_found_reg <= rdy_found_next;
            erl_found_reg <= erl_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_take)
        begin
            rdy_prio_reg  <= job.prio;
            rdy_arr_reg   <= job.arrival;
            rdy_idx_reg   <= idx;
            rdy_burst_reg <= job.burst;
        end
        if (erl_take)
        begin
            erl_prio_reg  <= job.prio;
            erl_arr_reg   <= job.arrival;
            erl_idx_reg   <= idx;
            erl_burst_reg <= job.burst;
        end
    end

    // nothing arrived yet: time jumps to the earliest arrival
    always_comb
    begin
        if (rdy_found_reg)
        begin
            pick.idx   = rdy_idx_reg;
            pick.start = tick;
            pick.burst = rdy_burst_reg;
        end
        else
        begin
            pick.idx   = erl_idx_reg;
            pick.start = {{(TICK_W-ARR_W){1'b0}}, erl_arr_reg};
            pick.burst = erl_burst_reg;
        end
    end

endmodule

`default_nettype wire

>>> hdl/priority_nonpreemptive_scheduler.sv
// ----------------------------------------------------------------------------
// priority_nonpreemptive_scheduler: non-preemptive priority scheduler
// Loads a process set, schedules it and reports per-process timing figures.
// ----------------------------------------------------------------------------
// usage
//   jobs: one process per beat (burst, arrival, priority, last flag), stored
//   in load order; beats past MAX_PROCS are dropped but their last flag counts
//   a beat with last_process set closes the set; jobs.ready then stays low
//   until the final result of the set has been loaded into the output register
//   loading takes one cycle per beat; scheduling n processes takes n
//   selection passes of ST_SCAN, ST_FLUSH and ST_PICK; the single select
//   unit sees one stored process per scan cycle through the registered read port
//   results: n beats in load order, each read (ST_RD) then loaded (ST_EMIT),
//   with running totals and last_result on the final beat
//   a stalled receiver holds the output register and the sequencer waits;
//   the next set may be loaded while the final result is still pending
//   reset clears the count, the scheduled flags and the output valid; the
//   process and timing RAMs are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module priority_nonpreemptive_scheduler
    import pns_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    pns_job_if.sink      jobs,
    pns_result_if.source results
);

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_FLUSH = 6'b000100,
        ST_PICK  = 6'b001000,
        ST_RD    = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]    count_reg, count_next;   // processes loaded
    logic [CNT_W-1:0]    n_reg, n_next;           // size of the set in work
    logic [CNT_W-1:0]    done_reg, done_next;     // processes scheduled
    logic [IDX_W-1:0]    scan_reg, scan_next;     // read pointer of a pass
    logic [IDX_W-1:0]    emit_reg, emit_next;     // result pointer
    logic                rd_vld_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [MAX_PROCS-1:0] flags_reg, flags_next;
    logic [SUM_W-1:0]    sum_ta_reg, sum_ta_next;
    logic [SUM_W-1:0]    sum_w_reg, sum_w_next;
    logic [SUM_W-1:0]    sum_r_reg, sum_r_next;
    logic                out_vld_reg, out_vld_next;

    logic                job_accept;
    logic                has_room;
    logic                out_load;

    // process RAM
    logic                job_we;
    logic [IDX_W-1:0]    job_raddr;
    job_rec_t            job_wdata;
    job_rec_t            job_rdata;

    // timing RAM
    logic                span_we;
    span_t               span_wdata;
    span_t               span_rdata;

    pick_t               pick;
    logic [TICK_W-1:0]   finish;
    logic [IDX_W-1:0]    pick_idx;

    // figures of the result being formed
    logic [SUM_W-1:0]    ta_full;
    logic [SUM_W-1:0]    w_full;
    logic [SUM_W-1:0]    r_full;
    logic                emit_last;

    assign jobs.ready = (state_reg == ST_LOAD);
    assign job_accept = jobs.valid && jobs.ready;
    assign has_room   = count_reg < CNT_W'(MAX_PROCS);

    assign job_we          = job_accept && has_room;
    assign job_wdata.burst   = jobs.burst_time;
    assign job_wdata.arrival = jobs.arrival_time;
    assign job_wdata.prio    = jobs.priority_level;
    assign job_raddr = (state_reg == ST_SCAN) ? scan_reg : emit_reg;

    pns_ram #(
        .WIDTH ($bits(job_rec_t)),
        .DEPTH (MAX_PROCS)
    ) u_job_ram (
        .clk   (clk),
        .we    (job_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (job_wdata),
        .raddr (job_raddr),
        .rdata (job_rdata)
    );

    // selection pass: one stored process per cycle into the select unit
    pns_select u_select (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  ((state_reg == ST_LOAD) || (state_reg == ST_PICK)),
        .sample (rd_vld_reg),
        .idx    (PIDX_W'(rd_idx_reg)),
        .job    (job_rdata),
        .done   (flags_reg[rd_idx_reg]),
        .tick   (tick_reg),
        .pick   (pick)
    );

    assign finish   = pick.start + {{(TICK_W-BURST_W){1'b0}}, pick.burst};
    assign pick_idx = pick.idx[IDX_W-1:0];

    assign span_we           = (state_reg == ST_PICK);
    assign span_wdata.start  = pick.start;
    assign span_wdata.finish = finish;

    pns_ram #(
        .WIDTH ($bits(span_t)),
        .DEPTH (MAX_PROCS)
    ) u_span_ram (
        .clk   (clk),
        .we    (span_we),
        .waddr (pick_idx),
        .wdata (span_wdata),
        .raddr (emit_reg),
        .rdata (span_rdata)
    );

    // result figures, no field exceeds its width for valid sets
    assign ta_full = SUM_W'(span_rdata.finish) - SUM_W'(job_rdata.arrival);
    assign w_full  = ta_full - SUM_W'(job_rdata.burst);
    assign r_full  = SUM_W'(span_rdata.start) - SUM_W'(job_rdata.arrival);
    assign emit_last = (CNT_W'(emit_reg) == n_reg - CNT_W'(1));

    assign out_load = (state_reg == ST_EMIT) && (!out_vld_reg || results.ready);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        done_next   = done_reg;
        scan_next   = scan_reg;
        emit_next   = emit_reg;
        tick_next   = tick_reg;
        flags_next  = flags_reg;
        sum_ta_next = sum_ta_reg;
        sum_w_next  = sum_w_reg;
        sum_r_next  = sum_r_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (job_accept)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (jobs.last_process)
                    begin
                        n_next     = has_room ? count_reg + CNT_W'(1) : count_reg;
                        done_next  = '0;
                        scan_next  = '0;
                        tick_next  = '0;
                        flags_next = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (CNT_W'(scan_reg) == n_reg - CNT_W'(1))
                begin
                    scan_next  = '0;
                    state_next = ST_FLUSH;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                flags_next[pick_idx] = 1'b1;
                tick_next = finish;
                done_next = done_reg + CNT_W'(1);
                if (done_reg + CNT_W'(1) == n_reg)
                begin
                    emit_next   = '0;
                    sum_ta_next = '0;
                    sum_w_next  = '0;
                    sum_r_next  = '0;
                    state_next  = ST_RD;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    sum_ta_next = sum_ta_reg + ta_full;
                    sum_w_next  = sum_w_reg + w_full;
                    sum_r_next  = sum_r_reg + r_full;
                    if (emit_last)
                    begin
                        count_next = '0;
                        tick_next  = '0;
                        flags_next = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        emit_next  = emit_reg + IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign out_vld_next = out_load ? 1'b1 : (results.ready ? 1'b0 : out_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            n_reg       <= '0;
            done_reg    <= '0;
            scan_reg    <= '0;
            emit_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            rd_idx_reg  <= '0;
            tick_reg    <= '0;
            flags_reg   <= '0;
            sum_ta_reg  <= '0;
            sum_w_reg   <= '0;
            sum_r_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            n_reg       <= n_next;
            done_reg    <= done_next;
            scan_reg    <= scan_next;
            emit_reg    <= emit_next;
            // read data of a scan address arrives in the next cycle
            rd_vld_reg  <= (state_reg == ST_SCAN);
            rd_idx_reg  <= scan_reg;
            tick_reg    <= tick_next;
            flags_reg   <= flags_next;
            sum_ta_reg  <= sum_ta_next;
            sum_w_reg   <= sum_w_next;
            sum_r_reg   <= sum_r_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // output register, payload only
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            results.process_index    <= PIDX_W'(emit_reg);
            results.completion_time  <= span_rdata.finish;
            results.turnaround_time  <= ta_full[DIFF_W-1:0];
            results.waiting_time     <= w_full[DIFF_W-1:0];
            results.response_time    <= r_full[DIFF_W-1:0];
            results.total_turnaround <= sum_ta_reg + ta_full;
            results.total_waiting    <= sum_w_reg + w_full;
            results.total_response   <= sum_r_reg + r_full;
            results.last_result      <= emit_last;
        end
    end

    assign results.valid = out_vld_reg;

endmodule

`default_nettype wire
